// ----- hdl/lpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg
// shared types and constants for the length-prefixed frame deframer
// ----------------------------------------------------------------------------
package lpd_pkg;

    // header layout, little-endian, length counts the header
    localparam int HEADER_BYTES = 10;
    localparam logic [15:0] HEADER_LEN = 16'(HEADER_BYTES);
    localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

    // byte positions within the header
    localparam logic [15:0] POS_LEN_LO   = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd1;
    localparam logic [15:0] POS_MAIN_LO  = 16'd2;
    localparam logic [15:0] POS_SEQ_B2   = 16'd8;
    localparam logic [15:0] POS_HDR_DONE = 16'(HEADER_BYTES - 1);

    typedef logic [3:0] field_idx_t;
    localparam field_idx_t IDX_MAIN_LO = 4'd2;
    localparam field_idx_t IDX_MAIN_HI = 4'd3;
    localparam field_idx_t IDX_SUB_LO  = 4'd4;
    localparam field_idx_t IDX_SUB_HI  = 4'd5;
    localparam field_idx_t IDX_SEQ_B0  = 4'd6;
    localparam field_idx_t IDX_SEQ_B1  = 4'd7;
    localparam field_idx_t IDX_SEQ_B2  = 4'd8;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_HEADER  = 2'd0;
    localparam kind_t KIND_PAYLOAD = 2'd1;
    localparam kind_t KIND_ERROR   = 2'd2;

    // operations handed from front to back
    typedef logic [1:0] op_t;
    localparam op_t OP_FIELD   = 2'd0;
    localparam op_t OP_HEADER  = 2'd1;
    localparam op_t OP_PAYLOAD = 2'd2;
    localparam op_t OP_ERROR   = 2'd3;

    typedef struct packed {
        op_t         op;
        field_idx_t  idx;
        logic [7:0]  data;
        logic        last;
        logic [15:0] plen;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hdl/lpd_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_ifs
// valid/ready channels for received bytes and for deframer results
// ----------------------------------------------------------------------------
interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] main_code;
    logic [15:0] sub_code;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;

    modport source (output valid, output kind, output main_code, output sub_code,
                    output sequence_number, output payload_length,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input main_code, input sub_code,
                    input sequence_number, input payload_length,
                    input data_byte, input last, output ready);
endinterface

// ----- hdl/lpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_front
// byte position tracking, length check and classification of each beat
// ----------------------------------------------------------------------------
module lpd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    lpd_byte_if.sink            rx,
    input  lpd_pkg::q_status_t  status,
    output logic                push,
    output lpd_pkg::q_entry_t   entry
);
    import lpd_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] max_len_reg;
    logic        accept;
    logic [15:0] full_len;
    logic        bad_len;
    logic [16:0] pos_inc;
    logic        fin;

    assign rx.ready = !status.full;
    assign accept   = rx.valid && rx.ready;
    assign full_len = {rx.rx_byte, len_reg[7:0]};
    assign bad_len  = (full_len > max_len_reg) || (full_len < HEADER_LEN);
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;
    assign fin      = pos_inc >= {1'b0, len_reg};

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        push        = 1'b0;
        entry.op    = OP_FIELD;
        entry.idx   = pos_reg[3:0];
        entry.data  = rx.rx_byte;
        entry.last  = 1'b0;
        entry.plen  = len_reg - HEADER_LEN;
        if (accept)
        begin
            if (pos_reg == POS_LEN_LO)
            begin
                len_next = {8'd0, rx.rx_byte};
                pos_next = POS_LEN_HI;
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                if (bad_len)
                begin
                    push       = 1'b1;
                    entry.op   = OP_ERROR;
                    entry.last = 1'b1;
                    pos_next   = POS_LEN_LO;
                end
                else
                begin
                    len_next = full_len;
                    pos_next = POS_MAIN_LO;
                end
            end
            else if (pos_reg inside {[POS_MAIN_LO:POS_SEQ_B2]})
            begin
                push     = 1'b1;
                pos_next = pos_inc[15:0];
            end
            else if (pos_reg == POS_HDR_DONE)
            begin
                push       = 1'b1;
                entry.op   = OP_HEADER;
                entry.last = (len_reg == HEADER_LEN);
                pos_next   = (len_reg == HEADER_LEN) ? POS_LEN_LO : HEADER_LEN;
            end
            else
            begin
                push       = 1'b1;
                entry.op   = OP_PAYLOAD;
                entry.last = fin;
                pos_next   = fin ? POS_LEN_LO : pos_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_LEN_LO;
            len_reg     <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    // a rejected length always sends the parser back to the length field
    a_bad_len_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_LEN_HI && bad_len) |=> (pos_reg == POS_LEN_LO))
        else $error("front did not resync after bad length");

endmodule

// ----- hdl/lpd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module lpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpd_pkg::q_entry_t   wr_entry,
    input  logic                pop,
    output lpd_pkg::q_entry_t   rd_entry,
    output lpd_pkg::q_status_t  status
);
    import lpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rd_entry     = slots[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");

endmodule

// ----- hdl/lpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_back
// header field assembly and result output register
// ----------------------------------------------------------------------------
module lpd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lpd_pkg::q_status_t  status,
    input  lpd_pkg::q_entry_t   entry,
    output logic                pop,
    lpd_result_if.source        res
);
    import lpd_pkg::*;

    logic [15:0] main_reg, main_next;
    logic [15:0] sub_reg, sub_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] plen_reg, plen_next;
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [15:0] main_out_reg, sub_out_reg, plen_out_reg;
    logic [31:0] seq_out_reg;
    logic [7:0]  data_out_reg;
    logic        last_out_reg;
    logic        produces;
    logic        load;

    assign produces = (entry.op != OP_FIELD);
    assign pop      = !status.empty && (!produces || !out_valid_reg || res.ready);
    assign load     = pop && produces;

    // lane writes into the gathered header fields
    always_comb
    begin
        main_next = main_reg;
        sub_next  = sub_reg;
        seq_next  = seq_reg;
        plen_next = plen_reg;
        if (pop && entry.op == OP_FIELD)
        begin
            case (entry.idx)
                IDX_MAIN_LO: main_next = {main_reg[15:8], entry.data};
                IDX_MAIN_HI: main_next = {entry.data, main_reg[7:0]};
                IDX_SUB_LO:  sub_next  = {sub_reg[15:8], entry.data};
                IDX_SUB_HI:  sub_next  = {entry.data, sub_reg[7:0]};
                IDX_SEQ_B0:  seq_next  = {24'd0, entry.data};
                IDX_SEQ_B1:  seq_next  = {seq_reg[31:16], entry.data, seq_reg[7:0]};
                IDX_SEQ_B2:  seq_next  = {seq_reg[31:24], entry.data, seq_reg[15:0]};
                default:     seq_next  = seq_reg;
            endcase
        end
        else if (pop && entry.op == OP_HEADER)
        begin
            seq_next  = {entry.data, seq_reg[23:0]};
            plen_next = entry.plen;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        sub_reg  <= sub_next;
        seq_reg  <= seq_next;
        plen_reg <= plen_next;
        if (load)
        begin
            case (entry.op)
                OP_HEADER:
                begin
                    kind_reg     <= KIND_HEADER;
                    main_out_reg <= main_next;
                    sub_out_reg  <= sub_next;
                    seq_out_reg  <= seq_next;
                    plen_out_reg <= entry.plen;
                    data_out_reg <= '0;
                    last_out_reg <= entry.last;
                end
                OP_PAYLOAD:
                begin
                    kind_reg     <= KIND_PAYLOAD;
                    main_out_reg <= main_reg;
                    sub_out_reg  <= sub_reg;
                    seq_out_reg  <= seq_reg;
                    plen_out_reg <= plen_reg;
                    data_out_reg <= entry.data;
                    last_out_reg <= entry.last;
                end
                default:
                begin
                    kind_reg     <= KIND_ERROR;
                    main_out_reg <= '0;
                    sub_out_reg  <= '0;
                    seq_out_reg  <= '0;
                    plen_out_reg <= '0;
                    data_out_reg <= '0;
                    last_out_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.kind            = kind_reg;
    assign res.main_code       = main_out_reg;
    assign res.sub_code        = sub_out_reg;
    assign res.sequence_number = seq_out_reg;
    assign res.payload_length  = plen_out_reg;
    assign res.data_byte       = data_out_reg;
    assign res.last            = last_out_reg;

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_ERROR) |->
            (res.last && res.main_code == '0 && res.sequence_number == '0 &&
             res.payload_length == '0 && res.data_byte == '0))
        else $error("error result carries stale fields");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> !$past(load))
        else $error("pending result overwritten");

endmodule

// ----- hdl/length_prefixed_packet_deframer_top.sv -----
`timescale 1ns / 1ps
// a byte that completes a result is written into the queue, then into the output register that drives res
// throughput: one byte per cycle while the queue is not full, set by the single-entry output register that
// refills on the same edge it is drained
// header bytes other than the tenth produce no result beat, except a rejected length, which gives an error beat
// reset (rst_n low, asynchronous) returns the parser to the length field,
// empties the queue and output, and loads max_packet_length with 8192
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_top
// splits a byte stream into length-prefixed frames: header result, payload
// beats with a last mark, and an error beat on an out-of-range length
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    lpd_byte_if.sink      rx,
    lpd_result_if.source  res
);
    import lpd_pkg::*;

    // front to queue
    logic      push;
    q_entry_t  wr_entry;
    // queue to back
    logic      pop;
    q_entry_t  rd_entry;
    q_status_t status;

    // front: keeps the byte position and frame length, checks the length
    // against max_packet_length and the header size on the second byte, tags every
    // beat that the back end needs (field byte, header done, payload byte, error)
    lpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx),
        .status    (status),
        .push      (push),
        .entry     (wr_entry)
    );

    // short queue so a stalled result sink does not stall the front at once
    lpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .status   (status)
    );

    // back: assembles main code, sub code and sequence number from the
    // tagged bytes and drives the registered result beat
    lpd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .entry  (rd_entry),
        .pop    (pop),
        .res    (res)
    );

endmodule

// ----- tb/sv/length_prefixed_packet_deframer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_top_tb
// self-checking bench: random framed byte streams go in on rx, a local
// parser model predicts every result beat, and res beats are compared field
// by field in order, across several length limits and idle patterns
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_top_tb;
    import lpd_pkg::*;

    // header positions not named in the package
    localparam logic [15:0] POS_MAIN_HI = 16'd3;
    localparam logic [15:0] POS_SUB_LO  = 16'd4;
    localparam logic [15:0] POS_SUB_HI  = 16'd5;
    localparam logic [15:0] POS_SEQ_B0  = 16'd6;
    localparam logic [15:0] POS_SEQ_B1  = 16'd7;

    localparam logic [15:0] LEN_ALL_ONES = 16'hFFFF;
    // longest payload of a random-length legal frame
    localparam int unsigned SHORT_PAYLOAD = 40;
    // limits up to this size also get frames of exactly the limit
    localparam logic [15:0] EXACT_LIMIT_MAX = 16'd64;
    // cycles for header bytes still inside the pipe to settle
    localparam int unsigned SETTLE_CYCLES = 8;
    // at most this many mismatch lines are printed
    localparam int unsigned PRINT_CAP = 200;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] main_code;
        logic [15:0] sub_code;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    lpd_byte_if   rx_if ();
    lpd_result_if res_if ();

    length_prefixed_packet_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if),
        .res       (res_if)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // stimulus and expectation stores
    logic [7:0]    pending_bytes [$];
    frame_result_t awaited_results [$];
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken  = 0;
    int unsigned   error_count  = 0;

    // idle odds in percent, sender and receiver
    int unsigned   send_idle;
    int unsigned   recv_idle;

    // parser model state
    logic [15:0]   parse_pos   = POS_LEN_LO;
    logic [15:0]   frame_len   = '0;
    logic [15:0]   main_acc    = '0;
    logic [15:0]   sub_acc     = '0;
    logic [31:0]   seq_acc     = '0;
    logic [15:0]   limit_len   = MAX_LEN_RESET;

    frame_result_t oldest_result;

    // directed opening: below-header length, far-over-limit length, empty
    // frame with all-ones fields, one-byte payload frame with zero fields, zero length
    logic [7:0] directed_bytes [27] = '{
        8'h09, 8'h00,
        8'hFF, 8'hFF,
        8'h0A, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF,
        8'h00, 8'h00
    };

    task automatic flag_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // result carrying the fields of the frame being parsed
    function automatic frame_result_t frame_fields(input kind_t k, input logic [7:0] d,
                                                   input logic ends);
        frame_result_t r;
        r.kind            = k;
        r.main_code       = main_acc;
        r.sub_code        = sub_acc;
        r.sequence_number = seq_acc;
        r.payload_length  = frame_len - HEADER_LEN;
        r.data_byte       = d;
        r.last            = ends;
        return r;
    endfunction

    // parser model: one received byte in, zero or one expected beat queued
    function automatic void parse_byte(input logic [7:0] b);
        frame_result_t r;
        logic          ends;
        r = '0;
        ends = 1'b0;
        if (parse_pos == POS_LEN_LO)
        begin
            frame_len = {8'h00, b};
            parse_pos = POS_LEN_HI;
        end
        else if (parse_pos == POS_LEN_HI)
        begin
            frame_len[15:8] = b;
            // length check on the second byte, error beat has only kind and last
            if (frame_len > limit_len || frame_len < HEADER_LEN)
            begin
                r.kind = KIND_ERROR;
                r.last = 1'b1;
                awaited_results.push_back(r);
                parse_pos = POS_LEN_LO;
            end
            else
            begin
                parse_pos = POS_MAIN_LO;
            end
        end
        else if (parse_pos < HEADER_LEN)
        begin
            case (parse_pos)
                POS_MAIN_LO:  main_acc = {8'h00, b};
                POS_MAIN_HI:  main_acc[15:8] = b;
                POS_SUB_LO:   sub_acc = {8'h00, b};
                POS_SUB_HI:   sub_acc[15:8] = b;
                POS_SEQ_B0:   seq_acc = {24'h000000, b};
                POS_SEQ_B1:   seq_acc[15:8] = b;
                POS_SEQ_B2:   seq_acc[23:16] = b;
                POS_HDR_DONE: seq_acc[31:24] = b;
                default: ;
            endcase
            if (parse_pos == POS_HDR_DONE)
            begin
                // empty payload closes the frame on the header beat
                ends = (frame_len == HEADER_LEN);
                awaited_results.push_back(frame_fields(KIND_HEADER, 8'h00, ends));
                parse_pos = ends ? POS_LEN_LO : HEADER_LEN;
            end
            else
            begin
                parse_pos = parse_pos + 16'd1;
            end
        end
        else
        begin
            ends = ({1'b0, parse_pos} + 17'd1 >= {1'b0, frame_len});
            awaited_results.push_back(frame_fields(KIND_PAYLOAD, b, ends));
            parse_pos = ends ? POS_LEN_LO : parse_pos + 16'd1;
        end
    endfunction

    // driver: offers the next pending byte unless idling, predicts on accept
    always @(posedge clk)
    begin
        if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1)
        begin
            parse_byte(rx_if.rx_byte);
            bytes_taken++;
        end
        if (rx_if.valid !== 1'b1 || rx_if.ready === 1'b1)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= pending_bytes.pop_front();
            end
            else
            begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_error($sformatf("unexpected beat kind %0d", res_if.kind));
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                compare_field("kind", res_if.kind, oldest_result.kind);
                compare_field("main_code", res_if.main_code, oldest_result.main_code);
                compare_field("sub_code", res_if.sub_code, oldest_result.sub_code);
                compare_field("sequence_number", res_if.sequence_number,
                              oldest_result.sequence_number);
                compare_field("payload_length", res_if.payload_length,
                              oldest_result.payload_length);
                compare_field("data_byte", res_if.data_byte, oldest_result.data_byte);
                compare_field("last", res_if.last, oldest_result.last);
            end
        end
        // receiver stalls at random
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // well-formed frame of the given total length, random content
    task automatic push_frame(input logic [15:0] len);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        repeat (HEADER_BYTES - 2) push_byte(8'($urandom));
        repeat (int'(len) - HEADER_BYTES) push_byte(8'($urandom));
    endtask

    // mostly valid frames, some rejected lengths that resync the parser
    task automatic push_stream(input int unsigned count);
        int unsigned first;
        int unsigned pick;
        int unsigned room;
        logic [15:0] len;
        first = bytes_queued;
        while (bytes_queued - first < count)
        begin
            pick = $urandom_range(99);
            if (limit_len < HEADER_LEN || pick < 15)
            begin
                if (limit_len != LEN_ALL_ONES && $urandom_range(1) == 1)
                    len = (pick < 8) ? limit_len + 16'd1
                                     : 16'($urandom_range(65535, int'(limit_len) + 1));
                else
                    len = 16'($urandom_range(HEADER_BYTES - 1, 0));
                push_byte(len[7:0]);
                push_byte(len[15:8]);
            end
            else
            begin
                room = limit_len - HEADER_LEN;
                if (room > SHORT_PAYLOAD)
                    room = SHORT_PAYLOAD;
                // frames right at the limit when the limit is small
                if (pick < 22 && limit_len <= EXACT_LIMIT_MAX)
                    len = limit_len;
                else
                    len = 16'(HEADER_BYTES + $urandom_range(room));
                push_frame(len);
            end
        end
    endtask

    // wait for every byte taken and every result beat seen, then let the
    // header bytes that cause no beat clear the pipe
    task automatic drain_all;
        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one phase: optional limit write while idle, then two bursts with the
    // sender held back in between until all beats are back
    task automatic run_phase(input logic [15:0] limit, input logic write_limit,
                             input int unsigned snd, input int unsigned rcv,
                             input int unsigned count);
        if (write_limit)
        begin
            drain_all();
            cfg_we    <= 1'b1;
            cfg_wdata <= limit;
            @(posedge clk);
            cfg_we    <= 1'b0;
            limit_len = limit;
        end
        send_idle = snd;
        recv_idle = rcv;
        push_stream(count / 2);
        drain_all();
        push_stream(count - count / 2);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        res_if.ready   = 1'b0;
        send_idle      = 37;
        recv_idle      = 72;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            push_byte(directed_bytes[i]);

        // sender sparse, receiver stalls often; reset limit first
        run_phase(MAX_LEN_RESET, 1'b0, 37, 72, 280);
        run_phase(HEADER_LEN, 1'b1, 37, 72, 150);
        // limit below the header: every length rejected
        run_phase(16'd0, 1'b1, 37, 72, 100);

        // roles swapped
        run_phase(LEN_ALL_ONES, 1'b1, 72, 37, 300);
        run_phase(HEADER_LEN - 16'd1, 1'b1, 72, 37, 100);
        run_phase(16'd37, 1'b1, 72, 37, 300);

        // no idling at all
        run_phase(16'($urandom_range(300, HEADER_BYTES + 1)), 1'b1, 0, 0, 300);
        run_phase(LEN_ALL_ONES, 1'b1, 0, 0, 100);
        // one frame well past the short payloads
        push_frame(16'd90);

        drain_all();
        repeat (20) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d beats never arrived", awaited_results.size()));

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lpd_pkg.sv
hdl/lpd_ifs.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/lpd_back.sv
hdl/length_prefixed_packet_deframer_top.sv
tb/sv/length_prefixed_packet_deframer_top_tb.sv
